[rtl/upd_pkg.sv]
// Shared types, character constants and hex helpers for the URL percent decoder.
// No dependencies; imported by every module of the block.
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int unsigned MAX_OUT   = 3;   // results one input can cause
  localparam int unsigned IDX_W     = $clog2(MAX_OUT);
  localparam int unsigned CNT_W     = $clog2(MAX_OUT + 1);

  localparam int unsigned QDEPTH    = 4;   // entries in the front-to-back queue
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  // Escape tracking state, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,   // no escape pending
    PH_PCT   = 3'b010,   // '%' seen
    PH_DIGIT = 3'b100    // '%' and one hex digit seen
  } upd_phase_t;

  // Work handed from the front to the back: the bytes one input produced.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;   // bytes[0] goes out first
    logic [CNT_W-1:0]        cnt;     // 1..MAX_OUT when queued
    logic                    fin;     // caused by the final input byte
  } upd_burst_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } upd_qstat_t;

  function automatic logic upd_is_hex(input logic [7:0] c);
    upd_is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Only meaningful for a hex character.
  function automatic logic [3:0] upd_hex_val(input logic [7:0] c);
    upd_hex_val = c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage

[rtl/upd_front.sv]
// Front end: accepts raw bytes, tracks the escape state, forms result bursts.
// Depends on upd_pkg.
module upd_front import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,    // in_final
  input  upd_qstat_t qstat,
  output logic       push,
  output upd_burst_t burst
);

  upd_phase_t phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       acc, hx, fresh_pct;
  logic [7:0] fresh_byte;

  assign in_tready = !qstat.full;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    hx         = upd_is_hex(in_tdata);
    fresh_pct  = (in_tdata == CH_PERCENT) && !in_tlast;
    fresh_byte = (in_tdata == CH_PLUS) ? CH_SPACE : in_tdata;
    burst.bytes = '0;
    burst.cnt   = '0;
    burst.fin   = in_tlast;
    phase_nxt   = PH_IDLE;
    held_nxt    = held_r;
    unique case (phase_r)
      PH_PCT: begin
        if (hx && !in_tlast) begin
          held_nxt  = in_tdata;
          phase_nxt = PH_DIGIT;
        end else if (hx) begin
          burst.bytes[0] = CH_PERCENT;
          burst.bytes[1] = in_tdata;
          burst.cnt      = CNT_W'(2);
        end else if (fresh_pct) begin
          // broken escape, and the breaking '%' opens a new one
          burst.bytes[0] = CH_PERCENT;
          burst.cnt      = CNT_W'(1);
          phase_nxt      = PH_PCT;
        end else begin
          burst.bytes[0] = CH_PERCENT;
          burst.bytes[1] = fresh_byte;
          burst.cnt      = CNT_W'(2);
        end
      end
      PH_DIGIT: begin
        if (hx) begin
          burst.bytes[0] = {upd_hex_val(held_r), upd_hex_val(in_tdata)};
          burst.cnt      = CNT_W'(1);
        end else if (fresh_pct) begin
          burst.bytes[0] = CH_PERCENT;
          burst.bytes[1] = held_r;
          burst.cnt      = CNT_W'(2);
          phase_nxt      = PH_PCT;
        end else begin
          burst.bytes[0] = CH_PERCENT;
          burst.bytes[1] = held_r;
          burst.bytes[2] = fresh_byte;
          burst.cnt      = CNT_W'(3);
        end
      end
      default: begin
        if (fresh_pct) begin
          phase_nxt = PH_PCT;
        end else begin
          burst.bytes[0] = fresh_byte;
          burst.cnt      = CNT_W'(1);
        end
      end
    endcase
  end

  assign push = acc && (burst.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (acc) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held_r <= held_nxt;
    end
  end

  // A final byte always produces output and leaves no escape pending.
  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |-> push)
    else $error("final byte produced no output");
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |=> (phase_r == PH_IDLE))
    else $error("escape pending after final byte");

endmodule

[rtl/upd_queue.sv]
// Short FIFO of result bursts between front and back.
// Depends on upd_pkg.
module upd_queue import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  upd_burst_t push_data,
  input  logic       pop,
  output upd_burst_t head,
  output upd_qstat_t qstat
);

  upd_burst_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]       count_r, count_nxt;

  assign head        = mem_r[rd_ptr_r];
  assign qstat.full  = (count_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!qstat.full || pop) && !(qstat.full && !pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

[rtl/upd_back.sv]
// Back end: walks each queued burst and drives the result register.
// Depends on upd_pkg.
module upd_back import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  upd_burst_t head,
  input  upd_qstat_t qstat,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tuser,   // run_end
  output logic       out_tlast    // text_end
);

  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r;
  logic             run_end_r, text_end_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ld, last;

  assign ld   = !qstat.empty && (!valid_r || out_tready);
  assign last = (CNT_W'(idx_r) == head.cnt - CNT_W'(1));
  assign pop  = ld && last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_tready;
    if (ld) begin
      valid_nxt = 1'b1;
      idx_nxt   = last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      byte_r     <= head.bytes[idx_r];
      run_end_r  <= last;
      text_end_r <= last && head.fin;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = run_end_r;
  assign out_tlast  = text_end_r;

  a_text_end_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tlast || out_tuser))
    else $error("text end without run end");
  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    !qstat.empty |-> (CNT_W'(idx_r) < head.cnt))
    else $error("burst index past burst length");

endmodule

[rtl/url_percent_decoder.sv]
// URL percent decoder top level: front end, burst queue and back end.
// Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
// Decodes an encoded string streamed one byte per transfer, tlast on its
// final byte. "%XY" with two hex digits (either case) yields one byte, '+'
// yields a space, anything else passes through. A broken escape is emitted
// literally and the byte that broke it is handled afresh, so one input
// transfer yields zero to three output transfers. Each output transfer
// carries the byte in tdata, tuser high on the last byte caused by its input,
// and tlast high on the final byte of the string. A decoded %00 is an
// ordinary byte. Input is taken every cycle while the four-entry burst queue
// has room; the output side emits one byte per cycle while out_tready allows,
// so input transfers that yield one byte run at one per cycle; the queue
// absorbs multi-byte bursts. Bytes pass through the queue, then the result
// register. After reset the block is ready at once.
module url_percent_decoder import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,    // in_final
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tuser,   // run_end
  output logic       out_tlast    // text_end
);

  upd_qstat_t qstat;
  upd_burst_t burst, head;
  logic       push, pop;

  // Escape tracking and burst forming, one input transfer per cycle while the queue has room.
  upd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .qstat     (qstat),
    .push      (push),
    .burst     (burst)
  );

  // Decouples input pace from output stalls and multi-byte bursts.
  upd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (burst),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Serializes each burst into output transfers through a result register.
  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
